FILE: src/assert_macros.svh
// Assertion helpers shared by the RTL files.
// Both macros clock on i_clk and stay quiet while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define UXF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Condition must never be seen at a clock edge out of reset.
`define UXF_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

FILE: src/uxf_pkg.sv
// ----------------------------------------------------------------------------
// uxf_pkg
// Types and constants of the XOR-checked UART frame receiver.
// ----------------------------------------------------------------------------
package uxf_pkg;

    localparam logic [7:0] HDR_FIRST        = 8'h55;
    localparam logic [7:0] HDR_SECOND       = 8'hAA;
    localparam logic [7:0] MIN_LENGTH       = 8'd4;
    localparam logic [7:0] CMD_POINT_REPORT = 8'h02;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_HDR2    = 3'd1,
        PH_LEN     = 3'd2,
        PH_CMD     = 3'd3,
        PH_SEQLO   = 3'd4,
        PH_SEQHI   = 3'd5,
        PH_PAYLOAD = 3'd6,
        PH_CHECK   = 3'd7
    } t_phase;

    typedef enum logic [1:0] {
        ST_GOOD   = 2'd0,
        ST_SHORT  = 2'd1,
        ST_BADSUM = 2'd2
    } t_status;

    typedef struct packed {
        t_status     status;
        logic [7:0]  command;
        logic [15:0] sequence_res;
        logic [7:0]  payload_count;
        logic        is_point_report;
        logic [7:0]  point_id;
        logic [7:0]  point_type;
        logic [15:0] point_length;
        logic [31:0] point_value;
    } t_result;

endpackage

FILE: src/uxf_parser.sv
// ----------------------------------------------------------------------------
// uxf_parser
// Frame state machine: header hunt, field capture, running XOR and
// data-point decode. Produces at most one result per byte.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module uxf_parser #(
    parameter int VALUE_BYTES = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_vld,
    input  logic            i_adv,
    input  logic [7:0]      i_byte,
    output logic            o_res_vld,
    output uxf_pkg::t_result o_res
);

    localparam int VW = VALUE_BYTES * 8;
    localparam int OW = (VW < 32) ? VW : 32;

    uxf_pkg::t_phase r_phase, n_phase;
    logic [7:0]      r_len,   n_len;
    logic [7:0]      r_cmd,   n_cmd;
    logic [15:0]     r_seq,   n_seq;
    logic [7:0]      r_seen,  n_seen;
    logic [7:0]      r_xor,   n_xor;
    logic [7:0]      r_pid,   n_pid;
    logic [7:0]      r_ptype, n_ptype;
    logic [15:0]     r_plen,  n_plen;
    logic [VW-1:0]   r_pval,  n_pval;

    logic [7:0] seen_inc;
    logic       len_short;
    logic       sum_good;

    assign seen_inc  = r_seen + 8'd1;
    assign len_short = i_byte < uxf_pkg::MIN_LENGTH;
    assign sum_good  = i_byte == r_xor;

    // next state
    always_comb begin
        n_phase = r_phase;
        if (i_adv) begin
            unique case (r_phase)
                uxf_pkg::PH_HUNT: begin
                    if (i_byte == uxf_pkg::HDR_FIRST) n_phase = uxf_pkg::PH_HDR2;
                end
                uxf_pkg::PH_HDR2: begin
                    if (i_byte == uxf_pkg::HDR_SECOND)     n_phase = uxf_pkg::PH_LEN;
                    else if (i_byte != uxf_pkg::HDR_FIRST) n_phase = uxf_pkg::PH_HUNT;
                end
                uxf_pkg::PH_LEN: begin
                    n_phase = len_short ? uxf_pkg::PH_HUNT : uxf_pkg::PH_CMD;
                end
                uxf_pkg::PH_CMD:   n_phase = uxf_pkg::PH_SEQLO;
                uxf_pkg::PH_SEQLO: n_phase = uxf_pkg::PH_SEQHI;
                uxf_pkg::PH_SEQHI: begin
                    n_phase = (r_len > uxf_pkg::MIN_LENGTH) ? uxf_pkg::PH_PAYLOAD
                                                            : uxf_pkg::PH_CHECK;
                end
                uxf_pkg::PH_PAYLOAD: begin
                    if (seen_inc >= r_len - uxf_pkg::MIN_LENGTH) n_phase = uxf_pkg::PH_CHECK;
                end
                uxf_pkg::PH_CHECK: n_phase = uxf_pkg::PH_HUNT;
                default:           n_phase = uxf_pkg::PH_HUNT;
            endcase
        end
    end

    // frame fields
    always_comb begin
        n_len   = r_len;
        n_cmd   = r_cmd;
        n_seq   = r_seq;
        n_seen  = r_seen;
        n_xor   = r_xor;
        n_pid   = r_pid;
        n_ptype = r_ptype;
        n_plen  = r_plen;
        n_pval  = r_pval;
        if (i_adv) begin
            unique case (r_phase)
                uxf_pkg::PH_HDR2: begin
                    // new frame: clear everything captured so far
                    if (i_byte == uxf_pkg::HDR_SECOND) begin
                        n_len   = '0;
                        n_cmd   = '0;
                        n_seq   = '0;
                        n_seen  = '0;
                        n_xor   = '0;
                        n_pid   = '0;
                        n_ptype = '0;
                        n_plen  = '0;
                        n_pval  = '0;
                    end
                end
                uxf_pkg::PH_LEN: begin
                    if (!len_short) begin
                        n_len = i_byte;
                        n_xor = i_byte;
                    end
                end
                uxf_pkg::PH_CMD: begin
                    n_cmd = i_byte;
                    n_xor = r_xor ^ i_byte;
                end
                uxf_pkg::PH_SEQLO: begin
                    n_seq = {8'h00, i_byte};
                    n_xor = r_xor ^ i_byte;
                end
                uxf_pkg::PH_SEQHI: begin
                    n_seq = {i_byte, r_seq[7:0]};
                    n_xor = r_xor ^ i_byte;
                end
                uxf_pkg::PH_PAYLOAD: begin
                    n_xor  = r_xor ^ i_byte;
                    n_seen = seen_inc;
                    if (r_seen == 8'd0) n_pid   = i_byte;
                    if (r_seen == 8'd1) n_ptype = i_byte;
                    if (r_seen == 8'd2) n_plen  = {r_plen[15:8], i_byte};
                    if (r_seen == 8'd3) n_plen  = {i_byte, r_plen[7:0]};
                    // value lanes: only bytes inside the declared point length
                    for (int j = 0; j < VALUE_BYTES; j++) begin
                        if (r_seen == 8'(4 + j) && 16'(j) < r_plen) begin
                            n_pval[j*8 +: 8] = r_pval[j*8 +: 8] | i_byte;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // result
    always_comb begin
        o_res     = '0;
        o_res_vld = 1'b0;
        if (i_vld && r_phase == uxf_pkg::PH_LEN && len_short) begin
            o_res_vld    = 1'b1;
            o_res.status = uxf_pkg::ST_SHORT;
        end else if (i_vld && r_phase == uxf_pkg::PH_CHECK) begin
            o_res_vld           = 1'b1;
            o_res.status        = sum_good ? uxf_pkg::ST_GOOD : uxf_pkg::ST_BADSUM;
            o_res.command       = r_cmd;
            o_res.sequence_res  = r_seq;
            o_res.payload_count = r_len - uxf_pkg::MIN_LENGTH;
            if (sum_good && r_cmd == uxf_pkg::CMD_POINT_REPORT) begin
                o_res.is_point_report = 1'b1;
                o_res.point_id        = r_pid;
                o_res.point_type      = r_ptype;
                o_res.point_length    = r_plen;
                o_res.point_value     = 32'(r_pval[OW-1:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= uxf_pkg::PH_HUNT;
            r_len   <= '0;
            r_cmd   <= '0;
            r_seq   <= '0;
            r_seen  <= '0;
            r_xor   <= '0;
            r_pid   <= '0;
            r_ptype <= '0;
            r_plen  <= '0;
            r_pval  <= '0;
        end else begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_cmd   <= n_cmd;
            r_seq   <= n_seq;
            r_seen  <= n_seen;
            r_xor   <= n_xor;
            r_pid   <= n_pid;
            r_ptype <= n_ptype;
            r_plen  <= n_plen;
            r_pval  <= n_pval;
        end
    end

    `UXF_ASSERT(a_check_returns_to_hunt,
        (i_adv && r_phase == uxf_pkg::PH_CHECK) |=> r_phase == uxf_pkg::PH_HUNT,
        "checksum byte did not end the frame")
    `UXF_ASSERT(a_point_only_when_good,
        (o_res_vld && o_res.is_point_report) |-> o_res.status == uxf_pkg::ST_GOOD,
        "point report on a bad frame")
    `UXF_ASSERT(a_short_result_clear,
        (o_res_vld && o_res.status == uxf_pkg::ST_SHORT) |->
            (o_res.command == 8'd0 && o_res.sequence_res == 16'd0 &&
             o_res.payload_count == 8'd0 && !o_res.is_point_report),
        "short-length result carries frame data")

endmodule

FILE: src/uxf_out_reg.sv
// ----------------------------------------------------------------------------
// uxf_out_reg
// Result register of the receiver: holds one result until it is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module uxf_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  uxf_pkg::t_result i_res,
    input  logic             i_ready,
    output logic             o_free,
    output logic             o_valid,
    output uxf_pkg::t_result o_res
);

    logic             r_vld;
    uxf_pkg::t_result r_res;

    assign o_free  = !r_vld || i_ready;
    assign o_valid = r_vld;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_load) begin
            r_vld <= 1'b1;
        end else if (i_ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    `UXF_NEVER(a_no_overwrite, i_load && r_vld && !i_ready,
        "result overwritten before it was taken")

endmodule

FILE: src/xor_checked_uart_frame_receiver.sv
// ----------------------------------------------------------------------------
// xor_checked_uart_frame_receiver
// Byte-serial deframer for 0x55 0xAA framed packets with an XOR checksum.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_ready with i_rx_byte, one received UART byte per
// transaction. Output channel: o_valid / i_ready with the result fields; one
// result per completed frame (status good or checksum mismatch) or per length
// byte below four (status short). Other bytes produce no result.
// Throughput: one byte per cycle while the result register does not stall.
// A byte passes an input register, the frame state machine and the result
// register, so its result is valid once both registers have taken it.
// When the result register is full and i_ready is low, a byte that would
// produce a result waits in the input register and o_ready drops; bytes that
// produce no result are not held up by a full result register.
// Reset (synchronous, i_rst_n low) empties both registers and returns the
// state machine to hunting for the first header byte.
// VALUE_BYTES sets how many value bytes of a data-point report are kept.
// ----------------------------------------------------------------------------
module xor_checked_uart_frame_receiver #(
    parameter int VALUE_BYTES = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [7:0]  o_command,
    output logic [15:0] o_sequence_res,
    output logic [7:0]  o_payload_count,
    output logic        o_is_point_report,
    output logic [7:0]  o_point_id,
    output logic [7:0]  o_point_type,
    output logic [15:0] o_point_length,
    output logic [31:0] o_point_value
);

    logic             r_in_vld;
    logic [7:0]       r_in_byte;
    logic             res_vld;
    uxf_pkg::t_result res;
    logic             out_free;
    logic             adv;
    uxf_pkg::t_result out_res;

    // advance unless a result is pending and the result register is blocked
    assign adv     = r_in_vld && (!res_vld || out_free);
    assign o_ready = !r_in_vld || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_ready) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_byte <= i_rx_byte;
        end
    end

    uxf_parser #(
        .VALUE_BYTES(VALUE_BYTES)
    ) u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vld     (r_in_vld),
        .i_adv     (adv),
        .i_byte    (r_in_byte),
        .o_res_vld (res_vld),
        .o_res     (res)
    );

    uxf_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (adv && res_vld),
        .i_res   (res),
        .i_ready (i_ready),
        .o_free  (out_free),
        .o_valid (o_valid),
        .o_res   (out_res)
    );

    assign o_status          = out_res.status;
    assign o_command         = out_res.command;
    assign o_sequence_res    = out_res.sequence_res;
    assign o_payload_count   = out_res.payload_count;
    assign o_is_point_report = out_res.is_point_report;
    assign o_point_id        = out_res.point_id;
    assign o_point_type      = out_res.point_type;
    assign o_point_length    = out_res.point_length;
    assign o_point_value     = out_res.point_value;

endmodule
